>>> design/fenwick_tree_rank_select_assert.svh
// Assertion shorthands shared by the controller and the datapath.
`ifndef FENWICK_TREE_RANK_SELECT_ASSERT_SVH
`define FENWICK_TREE_RANK_SELECT_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define FTRS_ASSERT_NOW(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define FTRS_ASSERT_NEXT(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ftrs_pkg.sv
`default_nettype none

package ftrs_pkg;

  localparam int MAX_POSITIONS = 1024;
  localparam int ADDR_W        = $clog2(MAX_POSITIONS);
  localparam int POS_W         = 11;
  localparam int WALK_W        = POS_W + 1;
  localparam int SUM_W         = 32;
  localparam int DELTA_W       = 16;
  localparam logic [POS_W-1:0] SIZE_RESET = POS_W'(MAX_POSITIONS);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_PREFIX = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_code_t;

  // Start point of a prefix walk
  typedef enum logic [1:0] {
    SRC_POS = 2'd0,
    SRC_MID = 2'd1,
    SRC_HI  = 2'd2
  } pfx_src_t;

  typedef struct packed {
    logic     capture;
    logic     start_add;
    logic     step_add;
    logic     start_pfx;
    pfx_src_t pfx_src;
    logic     step_pfx;
    logic     find_init;
    logic     find_update;
    logic     clr_step;
    logic     publish;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_code_t cmd_code;
    logic      add_live;
    logic      pfx_live;
    logic      rd_pend;
    logic      clr_last;
    logic      rank_zero;
    logic      rank_over;
    logic      search_open;
  } dp_status_t;

  // Clamp the programmed size into 1..MAX_POSITIONS.
  function automatic logic [POS_W-1:0] eff_size(input logic [POS_W-1:0] s);
    if (s == '0) begin
      return POS_W'(1);
    end else if (s > POS_W'(MAX_POSITIONS)) begin
      return POS_W'(MAX_POSITIONS);
    end
    return s;
  endfunction

  // Smallest power of two at or above the effective size.
  function automatic logic [POS_W-1:0] walk_limit(input logic [POS_W-1:0] s);
    logic [POS_W-1:0] lim;
    lim = POS_W'(MAX_POSITIONS);
    for (int i = ADDR_W; i >= 0; i--) begin
      if ((POS_W'(1) << i) >= s) begin
        lim = POS_W'(1) << i;
      end
    end
    return lim;
  endfunction

endpackage

`default_nettype wire

>>> design/ftrs_if.sv
`default_nettype none

// Command channel
interface ftrs_item_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        command;
  logic [ftrs_pkg::POS_W-1:0]        position;
  logic signed [ftrs_pkg::DELTA_W-1:0] delta;
  logic [ftrs_pkg::POS_W-1:0]        rank;

  modport source (output valid, command, position, delta, rank, input ready);
  modport sink   (input valid, command, position, delta, rank, output ready);
endinterface

// Result channel
interface ftrs_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [ftrs_pkg::SUM_W-1:0] sum_value;
  logic [ftrs_pkg::POS_W-1:0]        found_position;
  logic                              not_reached;

  modport source (output valid, sum_value, found_position, not_reached, input ready);
  modport sink   (input valid, sum_value, found_position, not_reached, output ready);
endinterface

`default_nettype wire

>>> design/ftrs_datapath.sv
`default_nettype none
`include "fenwick_tree_rank_select_assert.svh"

module ftrs_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  ftrs_pkg::ctrl_cmd_t               cmd,
  output ftrs_pkg::dp_status_t              status,
  input  logic                              cfg_we,
  input  logic [ftrs_pkg::POS_W-1:0]        cfg_data,
  input  logic [1:0]                        in_command,
  input  logic [ftrs_pkg::POS_W-1:0]        in_position,
  input  logic signed [ftrs_pkg::DELTA_W-1:0] in_delta,
  input  logic [ftrs_pkg::POS_W-1:0]        in_rank,
  output logic signed [ftrs_pkg::SUM_W-1:0] sum_value,
  output logic [ftrs_pkg::POS_W-1:0]        found_position,
  output logic                              not_reached
);
  import ftrs_pkg::*;

  logic [SUM_W-1:0]   tree_mem [MAX_POSITIONS];
  logic [SUM_W-1:0]   rdata;
  logic [POS_W-1:0]   size_q;
  cmd_code_t          cmd_q;
  logic [POS_W-1:0]   pos_q;
  logic [DELTA_W-1:0] delta_q;
  logic [POS_W-1:0]   rank_q;
  logic [WALK_W-1:0]  wpos;
  logic [WALK_W-1:0]  wpos_next;
  logic [WALK_W-1:0]  wlow;
  logic               rd_pend;
  logic [ADDR_W-1:0]  rd_addr_q;
  logic [SUM_W-1:0]   acc;
  logic [POS_W-1:0]   lo;
  logic [POS_W-1:0]   hi;
  logic [POS_W-1:0]   mid;
  logic [ADDR_W-1:0]  clr_addr;
  logic [POS_W-1:0]   eff;
  logic [POS_W-1:0]   lim;
  logic [POS_W-1:0]   pfx_src_pos;
  logic               add_live;
  logic               pfx_live;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               add_we;
  logic               clr_we;
  logic               acc_ge_rank;
  logic               rank_zero;
  logic               rank_over;

  // Size register and its derived limits
  always_ff @(posedge clk) begin
    if (rst) begin
      size_q <= SIZE_RESET;
    end else if (cfg_we) begin
      size_q <= cfg_data;
    end
  end

  assign eff = eff_size(size_q);
  assign lim = walk_limit(eff);

  // Hold the accepted command
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q   <= cmd_code_t'(in_command);
      pos_q   <= in_position;
      delta_q <= in_delta;
      rank_q  <= in_rank;
    end
  end

  // Walk position: lowest set bit up for add, down for prefix
  assign wlow     = wpos & (~wpos + WALK_W'(1));
  assign add_live = (wpos != '0) && (wpos <= {1'b0, lim});
  assign pfx_live = (wpos != '0);
  assign rd_en    = (cmd.step_add && add_live) || (cmd.step_pfx && pfx_live);
  assign rd_addr  = ADDR_W'(wpos - WALK_W'(1));
  assign mid      = POS_W'(({1'b0, lo} + {1'b0, hi}) >> 1);

  always_comb begin
    unique case (cmd.pfx_src)
      SRC_MID: pfx_src_pos = mid;
      SRC_HI:  pfx_src_pos = hi;
      default: pfx_src_pos = pos_q;
    endcase
  end

  always_comb begin
    wpos_next = wpos;
    if (cmd.start_add) begin
      wpos_next = {1'b0, pos_q};
    end else if (cmd.start_pfx) begin
      wpos_next = {1'b0, (pfx_src_pos > lim) ? lim : pfx_src_pos};
    end else if (cmd.step_add && add_live) begin
      wpos_next = wpos + wlow;
    end else if (cmd.step_pfx && pfx_live) begin
      wpos_next = wpos - wlow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
    end
    wpos      <= wpos_next;
    rd_addr_q <= rd_addr;
  end

  // Table memory: one read port, one write port
  assign add_we = cmd.step_add && rd_pend;
  assign clr_we = cmd.clr_step;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= tree_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_we) begin
      tree_mem[clr_addr] <= '0;
    end else if (add_we) begin
      tree_mem[rd_addr_q] <= rdata + {{(SUM_W-DELTA_W){delta_q[DELTA_W-1]}}, delta_q};
    end
  end

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // Accumulate the prefix sum
  always_ff @(posedge clk) begin
    if (cmd.start_pfx) begin
      acc <= '0;
    end else if (cmd.step_pfx && rd_pend) begin
      acc <= acc + rdata;
    end
  end

  // Binary search bounds
  assign acc_ge_rank = $signed(acc) >= $signed({{(SUM_W-POS_W){1'b0}}, rank_q});
  assign rank_zero   = (rank_q == '0);
  assign rank_over   = (rank_q > eff);

  always_ff @(posedge clk) begin
    if (cmd.find_init) begin
      lo <= rank_q - POS_W'(1);
      hi <= eff;
    end else if (cmd.find_update) begin
      if (acc_ge_rank) begin
        hi <= mid;
      end else begin
        lo <= mid;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      unique case (cmd_q)
        CMD_PREFIX: begin
          sum_value      <= $signed(acc);
          found_position <= '0;
          not_reached    <= 1'b0;
        end
        CMD_FIND: begin
          sum_value <= '0;
          priority if (rank_zero) begin
            found_position <= '0;
            not_reached    <= 1'b0;
          end else if (rank_over) begin
            found_position <= eff;
            not_reached    <= 1'b1;
          end else begin
            found_position <= hi;
            not_reached    <= !acc_ge_rank;
          end
        end
        default: begin
          sum_value      <= '0;
          found_position <= '0;
          not_reached    <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    status.cmd_code    = cmd_q;
    status.add_live    = add_live;
    status.pfx_live    = pfx_live;
    status.rd_pend     = rd_pend;
    status.clr_last    = (clr_addr == {ADDR_W{1'b1}});
    status.rank_zero   = rank_zero;
    status.rank_over   = rank_over;
    status.search_open = ((hi - lo) > POS_W'(1));
  end

  `FTRS_ASSERT_NOW(a_single_write, clk, rst, clr_we, !add_we, "clear and add write together")
  `FTRS_ASSERT_NEXT(a_bounds_ordered, clk, rst, cmd.find_update, hi > lo, "search bounds crossed")

endmodule

`default_nettype wire

>>> design/ftrs_ctrl.sv
`default_nettype none
`include "fenwick_tree_rank_select_assert.svh"

module ftrs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ftrs_pkg::ctrl_cmd_t  cmd,
  input  ftrs_pkg::dp_status_t status
);
  import ftrs_pkg::*;

  typedef enum logic [3:0] {
    S_CLR_INIT,
    S_IDLE,
    S_DISPATCH,
    S_CLR,
    S_ADD,
    S_PFX,
    S_FIND_INIT,
    S_FIND_CHK,
    S_FIND_WALK,
    S_FIND_UPD,
    S_FIND_LAST,
    S_PUB
  } state_t;

  state_t state;
  state_t state_next;
  logic   walk_done;

  assign in_ready = (state == S_IDLE);

  // Decode commands and the next state
  always_comb begin
    cmd        = '0;
    cmd.pfx_src = SRC_POS;
    state_next = state;
    walk_done  = !status.rd_pend;
    unique case (state)
      S_CLR_INIT: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (status.cmd_code)
          CMD_ADD: begin
            cmd.start_add = 1'b1;
            state_next    = S_ADD;
          end
          CMD_PREFIX: begin
            cmd.start_pfx = 1'b1;
            state_next    = S_PFX;
          end
          CMD_FIND:  state_next = S_FIND_INIT;
          CMD_CLEAR: state_next = S_CLR;
          default:   state_next = S_PUB;
        endcase
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_next = S_PUB;
      end
      S_ADD: begin
        cmd.step_add = 1'b1;
        if (!status.add_live && walk_done) state_next = S_PUB;
      end
      S_PFX: begin
        cmd.step_pfx = 1'b1;
        if (!status.pfx_live && walk_done) state_next = S_PUB;
      end
      S_FIND_INIT: begin
        cmd.find_init = 1'b1;
        state_next    = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        priority if (status.rank_zero || status.rank_over) begin
          state_next = S_PUB;
        end else if (status.search_open) begin
          cmd.start_pfx = 1'b1;
          cmd.pfx_src   = SRC_MID;
          state_next    = S_FIND_WALK;
        end else begin
          cmd.start_pfx = 1'b1;
          cmd.pfx_src   = SRC_HI;
          state_next    = S_FIND_LAST;
        end
      end
      S_FIND_WALK: begin
        cmd.step_pfx = 1'b1;
        if (!status.pfx_live && walk_done) state_next = S_FIND_UPD;
      end
      S_FIND_UPD: begin
        cmd.find_update = 1'b1;
        state_next      = S_FIND_CHK;
      end
      S_FIND_LAST: begin
        cmd.step_pfx = 1'b1;
        if (!status.pfx_live && walk_done) state_next = S_PUB;
      end
      S_PUB: begin
        cmd.publish = !out_valid || out_ready;
        if (cmd.publish) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `FTRS_ASSERT_NOW(a_pub_free, clk, rst, cmd.publish, (!out_valid || out_ready), "result overwritten")
  `FTRS_ASSERT_NEXT(a_accept_runs, clk, rst, (in_valid && in_ready), state == S_DISPATCH, "beat lost")

endmodule

`default_nettype wire

>>> design/fenwick_tree_rank_select.sv
`default_nettype none

// Channel   Role     Handshake      Payload
// item      sink     valid/ready    command, position, delta, rank
// result    source   valid/ready    sum_value, found_position, not_reached
// cfg       write    cfg_we         cfg_data (size_in_use)
//
// One item at a time; a table walk reads one entry per cycle from the single read port.
// Find runs up to 11 prefix walks, with a bound update after each search step.
// Clear sweeps all 1024 entries, one a cycle; after reset the same sweep runs before
// the first item beat is taken.
// A result waits in the output register; the next item beat is taken meanwhile.

module fenwick_tree_rank_select (
  input  logic                       clk,
  input  logic                       rst,
  ftrs_item_if.sink                  item,
  ftrs_result_if.source              result,
  input  logic                       cfg_we,
  input  logic [ftrs_pkg::POS_W-1:0] cfg_data
);
  import ftrs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ftrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  ftrs_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_command     (item.command),
    .in_position    (item.position),
    .in_delta       (item.delta),
    .in_rank        (item.rank),
    .sum_value      (result.sum_value),
    .found_position (result.found_position),
    .not_reached    (result.not_reached)
  );

endmodule

`default_nettype wire
